// ----- sv/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the frame receiver RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is held low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, checked on every edge including reset.
`define ASSERT_CLK_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- sv/slcfr_pkg.sv -----
// ----------------------------------------------------------------------------
// slcfr_pkg
// Types, constants and the CRC-16/CCITT-FALSE byte update for the
// sync/length/CRC frame receiver.
// ----------------------------------------------------------------------------
package slcfr_pkg;

    localparam int unsigned PAYLOAD_LIMIT = 1024;

    localparam int unsigned DATA_W  = 80;
    localparam int unsigned USER_W  = 2;
    localparam int unsigned ADDR_W  = 4;
    localparam int unsigned APB_W   = 32;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] TALLY_MAX = 16'hFFFF;

    localparam logic [15:0] SYNC_PAT_RST     = 16'hAA55;
    localparam logic [10:0] COPY_LIMIT_RST   = 11'd1024;
    localparam logic [6:0]  RESYNC_LIMIT_RST = 7'd64;

    typedef logic [1:0] t_status;
    localparam t_status ST_OK        = 2'd0;
    localparam t_status ST_CRC_ERR   = 2'd1;
    localparam t_status ST_LEN_ERR   = 2'd2;
    localparam t_status ST_SYNC_LOST = 2'd3;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_SYNC_PAT     = 2'd0;
    localparam t_reg_idx REG_COPY_LIMIT   = 2'd1;
    localparam t_reg_idx REG_RESYNC_LIMIT = 2'd2;

    typedef enum logic [8:0] {
        PH_SYNC1   = 9'b0_0000_0001,
        PH_SYNC2   = 9'b0_0000_0010,
        PH_HUNT    = 9'b0_0000_0100,
        PH_LENHI   = 9'b0_0000_1000,
        PH_LENLO   = 9'b0_0001_0000,
        PH_CMD     = 9'b0_0010_0000,
        PH_PAYLOAD = 9'b0_0100_0000,
        PH_CRCHI   = 9'b0_1000_0000,
        PH_CRCLO   = 9'b1_0000_0000
    } t_phase;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {b, 8'h00};
        for (int j = 0; j < 8; j++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == TALLY_MAX) ? v : v + 16'd1;
    endfunction

endpackage

// ----- sv/sync_length_crc_frame_receiver_core.sv -----
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver_core
// Byte-wise frame parser: sync word, length, command, payload, CRC-16.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one received byte per request in tdata[7:0].
//   m_axis carries results: payload bytes (tlast low) as they arrive, up to
//   copy_limit per frame, and one status result (tlast high) that ends each
//   frame or error. tuser holds the status code.
//   The APB port sets the sync pattern (0x0), copy_limit (0x4),
//   resync_limit (0x8); write only while the block is idle.
// Timing:
//   One byte per cycle sustained while m_axis takes results. A result is
//   registered in the cycle after the byte that causes it, from a single
//   output register; CRC update and parser step run combinationally before it.
//   A byte is taken whenever the output register is empty or being drained.
// Reset:
//   Synchronous, active low. Parser returns to sync search, tallies clear,
//   registers return to 0xAA55 / 1024 / 64, output register empties.
//   While m_axis stalls with a result pending, s_axis_tready stays low.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sync_length_crc_frame_receiver_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [7:0] rx_byte
    input  logic [7:0]                      s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [7:0] data_byte, [15:8] command, [26:16] copied_length,
    // [42:27] length field, [58:43] error_tally, [74:59] good_frame_tally,
    // [79:75] zero
    output logic [slcfr_pkg::DATA_W-1:0]    m_axis_tdata,
    output logic                            m_axis_tlast,
    // [1:0] status
    output logic [slcfr_pkg::USER_W-1:0]    m_axis_tuser,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [slcfr_pkg::ADDR_W-1:0]    paddr,
    input  logic [slcfr_pkg::APB_W-1:0]     pwdata,
    output logic [slcfr_pkg::APB_W-1:0]     prdata,
    output logic                            pready
);
    import slcfr_pkg::*;

    // config
    logic [15:0] r_sync_pat;
    logic [10:0] r_copy_limit;
    logic [6:0]  r_resync_limit;

    // parser state
    t_phase      r_phase,     n_phase;
    logic [7:0]  r_prev,      n_prev;
    logic [6:0]  r_hunt,      n_hunt;
    logic [15:0] r_flen,      n_flen;
    logic [10:0] r_bidx,      n_bidx;
    logic [15:0] r_remain,    n_remain;
    logic [15:0] r_crc,       n_crc;
    logic [7:0]  r_cmd,       n_cmd;
    logic [7:0]  r_crc_hi,    n_crc_hi;
    logic [15:0] r_err_cnt,   n_err_cnt;
    logic [15:0] r_good_cnt,  n_good_cnt;

    // output register
    logic        r_out_valid;
    logic        r_out_last,  n_out_last;
    t_status     r_out_st,    n_out_st;
    logic [7:0]  r_out_byte,  n_out_byte;
    logic [7:0]  r_out_cmd,   n_out_cmd;
    logic [10:0] r_out_copy,  n_out_copy;
    logic [15:0] r_out_plen,  n_out_plen;
    logic [15:0] r_out_err,   n_out_err;
    logic [15:0] r_out_good,  n_out_good;
    logic        n_emit;

    logic        s_accept;
    logic        cfg_wr;
    t_reg_idx    cfg_idx;
    logic [15:0] rx_word;
    logic [15:0] crc_upd;
    logic [15:0] remain_dec;
    logic [15:0] crc_recv;

    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign rx_word       = {r_prev, s_axis_tdata};
    assign crc_upd       = crc_byte(r_crc, s_axis_tdata);
    assign remain_dec    = r_remain - 16'd1;
    assign crc_recv      = {r_crc_hi, s_axis_tdata};

    // ---------------- parser step ----------------
    always_comb begin
        n_phase    = r_phase;
        n_prev     = r_prev;
        n_hunt     = r_hunt;
        n_flen     = r_flen;
        n_bidx     = r_bidx;
        n_remain   = r_remain;
        n_crc      = r_crc;
        n_cmd      = r_cmd;
        n_crc_hi   = r_crc_hi;
        n_err_cnt  = r_err_cnt;
        n_good_cnt = r_good_cnt;
        n_emit     = 1'b0;
        n_out_last = 1'b1;
        n_out_st   = ST_OK;
        n_out_byte = 8'd0;
        n_out_cmd  = 8'd0;
        n_out_copy = 11'd0;
        n_out_plen = 16'd0;

        unique case (r_phase)
            PH_SYNC2: begin
                n_prev = s_axis_tdata;
                if (rx_word == r_sync_pat) begin
                    n_phase = PH_LENHI;
                end else begin
                    n_err_cnt = sat_inc(r_err_cnt);
                    n_hunt    = 7'd0;
                    if (r_resync_limit == 7'd0) begin
                        n_phase  = PH_SYNC1;
                        n_emit   = 1'b1;
                        n_out_st = ST_SYNC_LOST;
                    end else begin
                        n_phase = PH_HUNT;
                    end
                end
            end
            PH_HUNT: begin
                n_prev = s_axis_tdata;
                n_hunt = r_hunt + 7'd1;
                if (rx_word == r_sync_pat) begin
                    n_phase = PH_LENHI;
                end else if (n_hunt >= r_resync_limit) begin
                    n_phase  = PH_SYNC1;
                    n_emit   = 1'b1;
                    n_out_st = ST_SYNC_LOST;
                end
            end
            PH_LENHI: begin
                n_flen  = {s_axis_tdata, 8'h00};
                n_phase = PH_LENLO;
            end
            PH_LENLO: begin
                n_flen = {r_flen[15:8], s_axis_tdata};
                if (32'(n_flen) > PAYLOAD_LIMIT) begin
                    n_err_cnt  = sat_inc(r_err_cnt);
                    n_phase    = PH_SYNC1;
                    n_emit     = 1'b1;
                    n_out_st   = ST_LEN_ERR;
                    n_out_plen = n_flen;
                end else begin
                    n_crc   = CRC_INIT;
                    n_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                n_cmd    = s_axis_tdata;
                n_crc    = crc_upd;
                n_bidx   = 11'd0;
                n_remain = r_flen;
                n_phase  = (r_flen == 16'd0) ? PH_CRCHI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc    = crc_upd;
                n_remain = remain_dec;
                if (remain_dec == 16'd0) begin
                    n_phase = PH_CRCHI;
                end
                if (r_bidx < r_copy_limit) begin
                    n_bidx     = r_bidx + 11'd1;
                    n_emit     = 1'b1;
                    n_out_last = 1'b0;
                    n_out_byte = s_axis_tdata;
                    n_out_cmd  = r_cmd;
                    n_out_copy = n_bidx;
                    n_out_plen = r_flen;
                end
            end
            PH_CRCHI: begin
                n_crc_hi = s_axis_tdata;
                n_phase  = PH_CRCLO;
            end
            PH_CRCLO: begin
                if (crc_recv == r_crc) begin
                    n_good_cnt = sat_inc(r_good_cnt);
                    n_out_st   = ST_OK;
                end else begin
                    n_err_cnt = sat_inc(r_err_cnt);
                    n_out_st  = ST_CRC_ERR;
                end
                n_phase    = PH_SYNC1;
                n_emit     = 1'b1;
                n_out_cmd  = r_cmd;
                n_out_copy = r_bidx;
                n_out_plen = r_flen;
            end
            default: begin
                n_prev  = s_axis_tdata;
                n_phase = PH_SYNC2;
            end
        endcase

        n_out_err  = n_err_cnt;
        n_out_good = n_good_cnt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SYNC1;
            r_prev     <= 8'd0;
            r_hunt     <= 7'd0;
            r_flen     <= 16'd0;
            r_bidx     <= 11'd0;
            r_remain   <= 16'd0;
            r_crc      <= CRC_INIT;
            r_cmd      <= 8'd0;
            r_crc_hi   <= 8'd0;
            r_err_cnt  <= 16'd0;
            r_good_cnt <= 16'd0;
        end else if (s_accept) begin
            r_phase    <= n_phase;
            r_prev     <= n_prev;
            r_hunt     <= n_hunt;
            r_flen     <= n_flen;
            r_bidx     <= n_bidx;
            r_remain   <= n_remain;
            r_crc      <= n_crc;
            r_cmd      <= n_cmd;
            r_crc_hi   <= n_crc_hi;
            r_err_cnt  <= n_err_cnt;
            r_good_cnt <= n_good_cnt;
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_accept) begin
            r_out_valid <= n_emit;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept && n_emit) begin
            r_out_last <= n_out_last;
            r_out_st   <= n_out_st;
            r_out_byte <= n_out_byte;
            r_out_cmd  <= n_out_cmd;
            r_out_copy <= n_out_copy;
            r_out_plen <= n_out_plen;
            r_out_err  <= n_out_err;
            r_out_good <= n_out_good;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tlast  = r_out_last;
    assign m_axis_tuser  = r_out_st;
    assign m_axis_tdata  = {5'd0, r_out_good, r_out_err, r_out_plen,
                            r_out_copy, r_out_cmd, r_out_byte};

    // ---------------- APB registers ----------------
    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sync_pat     <= SYNC_PAT_RST;
            r_copy_limit   <= COPY_LIMIT_RST;
            r_resync_limit <= RESYNC_LIMIT_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_SYNC_PAT:     r_sync_pat     <= pwdata[15:0];
                REG_COPY_LIMIT:   r_copy_limit   <= pwdata[10:0];
                REG_RESYNC_LIMIT: r_resync_limit <= pwdata[6:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_SYNC_PAT:     prdata = {16'd0, r_sync_pat};
            REG_COPY_LIMIT:   prdata = {21'd0, r_copy_limit};
            REG_RESYNC_LIMIT: prdata = {25'd0, r_resync_limit};
            default:          prdata = '0;
        endcase
    end

    // ---------------- assertions ----------------
    `ASSERT_CLK(a_crclo_emits, i_clk, i_rst_n, (s_accept && r_phase == PH_CRCLO) |=> (r_out_valid && r_out_last), "CRC low byte did not produce a status result")
    `ASSERT_CLK(a_payload_remain, i_clk, i_rst_n, (r_phase == PH_PAYLOAD) |-> (r_remain != 16'd0), "payload phase with no bytes remaining")
    `ASSERT_CLK(a_err_saturates, i_clk, i_rst_n, (r_err_cnt == TALLY_MAX) |=> (r_err_cnt == TALLY_MAX), "error tally wrapped")
    `ASSERT_CLK(a_data_copy_bound, i_clk, i_rst_n, (r_out_valid && !r_out_last) |-> (r_out_copy != 11'd0), "data result with zero copied length")

endmodule

// ----- bench/sync_length_crc_frame_receiver_core_tb.sv -----
// ----------------------------------------------------------------------------
// sync_length_crc_frame_receiver_core_tb
// Self-checking bench for the sync/length/CRC frame receiver.
// Drives byte streams made of well-formed frames, corrupted CRCs, oversized
// lengths, bad sync pairs with resync hunts and raw noise, under several
// register settings and random stalls on both streams. A bit-accurate parser
// in the bench predicts every payload and status result, and the output
// stream is compared field by field. Ends with a long output hold-off.
// ----------------------------------------------------------------------------
module sync_length_crc_frame_receiver_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slcfr_pkg::*;

    localparam int CYCLE_LIMIT = 2_500_000;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASE_BYTES = 190;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        is_last;
        t_status     status;
        logic [7:0]  command;
        logic [10:0] copied_len;
        logic [15:0] len_field;
        logic [15:0] err_tally;
        logic [15:0] good_tally;
    } t_rx_result;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [7:0]          s_axis_tdata;   // [7:0] rx_byte
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    // [7:0] data_byte, [15:8] command, [26:16] copied_length,
    // [42:27] length field, [58:43] error_tally, [74:59] good_frame_tally
    logic [DATA_W-1:0]   m_axis_tdata;
    logic                m_axis_tlast;
    logic [USER_W-1:0]   m_axis_tuser;   // [1:0] status
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [ADDR_W-1:0]   paddr;
    logic [APB_W-1:0]    pwdata;
    logic [APB_W-1:0]    prdata;
    logic                pready;

    sync_length_crc_frame_receiver_core dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // parser state and register copies
    logic [15:0] cfg_sync;
    logic [10:0] cfg_copy_limit;
    logic [6:0]  cfg_resync;
    t_phase      rx_phase;
    logic [7:0]  prev_byte;
    logic [6:0]  hunt_cnt;
    logic [15:0] hdr_len;
    logic [10:0] passed_cnt;
    logic [15:0] bytes_left;
    logic [15:0] crc_acc;
    logic [7:0]  cmd_held;
    logic [7:0]  crc_hi;
    logic [15:0] err_cnt;
    logic [15:0] good_cnt;

    t_rx_result  frame_results_due[$];
    logic [7:0]  payload_buf[$];

    int  mismatches = 0;
    int  cycles = 0;
    int  bytes_sent = 0;
    int  n_ok = 0, n_crc = 0, n_len = 0, n_lost = 0, n_data = 0;
    bit  idle_on = 1'b0;
    bit  rx_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("Timeout after %0d cycles", cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        logic        fb;
        c = crc;
        for (int i = 7; i >= 0; i--) begin
            fb = c[15] ^ b[i];
            c  = {c[14:0], 1'b0};
            if (fb) begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic logic [15:0] tally_bump(input logic [15:0] v);
        return (&v) ? v : v + 16'd1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (!idle_on) begin
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 70) begin
            return 0;
        end else if (r < 94) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    task automatic parser_reset();
        cfg_sync       = SYNC_PAT_RST;
        cfg_copy_limit = COPY_LIMIT_RST;
        cfg_resync     = RESYNC_LIMIT_RST;
        rx_phase       = PH_SYNC1;
        prev_byte      = '0;
        hunt_cnt       = '0;
        hdr_len        = '0;
        passed_cnt     = '0;
        bytes_left     = '0;
        crc_acc        = CRC_INIT;
        cmd_held       = '0;
        crc_hi         = '0;
        err_cnt        = '0;
        good_cnt       = '0;
    endtask

    // advance the parser by one received byte and queue the result it causes
    task automatic step_frame_parser(input logic [7:0] b);
        t_rx_result  r;
        logic [15:0] word;
        logic [15:0] rx_crc;
        bit          emit;
        word = {prev_byte, b};
        r    = '0;
        emit = 1'b0;
        case (rx_phase)
            PH_SYNC2: begin
                prev_byte = b;
                if (word == cfg_sync) begin
                    rx_phase = PH_LENHI;
                end else begin
                    err_cnt  = tally_bump(err_cnt);
                    hunt_cnt = '0;
                    if (cfg_resync == 0) begin
                        rx_phase = PH_SYNC1;
                        r.is_last = 1'b1;
                        r.status  = ST_SYNC_LOST;
                        emit      = 1'b1;
                    end else begin
                        rx_phase = PH_HUNT;
                    end
                end
            end
            PH_HUNT: begin
                prev_byte = b;
                hunt_cnt  = hunt_cnt + 7'd1;
                if (word == cfg_sync) begin
                    rx_phase = PH_LENHI;
                end else if (hunt_cnt >= cfg_resync) begin
                    rx_phase  = PH_SYNC1;
                    r.is_last = 1'b1;
                    r.status  = ST_SYNC_LOST;
                    emit      = 1'b1;
                end
            end
            PH_LENHI: begin
                hdr_len  = {b, 8'h00};
                rx_phase = PH_LENLO;
            end
            PH_LENLO: begin
                hdr_len = {hdr_len[15:8], b};
                if (hdr_len > PAYLOAD_LIMIT) begin
                    err_cnt     = tally_bump(err_cnt);
                    rx_phase    = PH_SYNC1;
                    r.is_last   = 1'b1;
                    r.status    = ST_LEN_ERR;
                    r.len_field = hdr_len;
                    emit        = 1'b1;
                end else begin
                    crc_acc  = CRC_INIT;
                    rx_phase = PH_CMD;
                end
            end
            PH_CMD: begin
                cmd_held   = b;
                crc_acc    = crc16_step(crc_acc, b);
                passed_cnt = '0;
                bytes_left = hdr_len;
                rx_phase   = (hdr_len == 0) ? PH_CRCHI : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                crc_acc    = crc16_step(crc_acc, b);
                bytes_left = bytes_left - 16'd1;
                if (bytes_left == 0) begin
                    rx_phase = PH_CRCHI;
                end
                if (passed_cnt < cfg_copy_limit) begin
                    passed_cnt   = passed_cnt + 11'd1;
                    r.data_byte  = b;
                    r.status     = ST_OK;
                    r.command    = cmd_held;
                    r.copied_len = passed_cnt;
                    r.len_field  = hdr_len;
                    emit         = 1'b1;
                end
            end
            PH_CRCHI: begin
                crc_hi   = b;
                rx_phase = PH_CRCLO;
            end
            PH_CRCLO: begin
                rx_crc = {crc_hi, b};
                if (rx_crc == crc_acc) begin
                    good_cnt = tally_bump(good_cnt);
                    r.status = ST_OK;
                end else begin
                    err_cnt  = tally_bump(err_cnt);
                    r.status = ST_CRC_ERR;
                end
                rx_phase     = PH_SYNC1;
                r.is_last    = 1'b1;
                r.command    = cmd_held;
                r.copied_len = passed_cnt;
                r.len_field  = hdr_len;
                emit         = 1'b1;
            end
            default: begin
                prev_byte = b;
                rx_phase  = PH_SYNC2;
            end
        endcase
        if (emit) begin
            r.err_tally  = err_cnt;
            r.good_tally = good_cnt;
            frame_results_due.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            step_frame_parser(s_axis_tdata);
        end
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatches++;
        $display("ERROR @%0t: %s got 0x%0h want 0x%0h", $time, what, got, want);
    endtask

    always @(posedge i_clk) begin : result_check
        t_rx_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (frame_results_due.size() == 0) begin
                report_mismatch("result with nothing pending", m_axis_tdata[31:0], 32'd0);
            end else begin
                want = frame_results_due.pop_front();
                if (m_axis_tdata[7:0] != want.data_byte)
                    report_mismatch("data_byte", 32'(m_axis_tdata[7:0]),
                                    32'(want.data_byte));
                if (m_axis_tlast != want.is_last)
                    report_mismatch("is_last", 32'(m_axis_tlast), 32'(want.is_last));
                if (m_axis_tuser != want.status)
                    report_mismatch("status", 32'(m_axis_tuser), 32'(want.status));
                if (m_axis_tdata[15:8] != want.command)
                    report_mismatch("command", 32'(m_axis_tdata[15:8]),
                                    32'(want.command));
                if (m_axis_tdata[26:16] != want.copied_len)
                    report_mismatch("copied_length", 32'(m_axis_tdata[26:16]),
                                    32'(want.copied_len));
                if (m_axis_tdata[42:27] != want.len_field)
                    report_mismatch("length field", 32'(m_axis_tdata[42:27]),
                                    32'(want.len_field));
                if (m_axis_tdata[58:43] != want.err_tally)
                    report_mismatch("error_tally", 32'(m_axis_tdata[58:43]),
                                    32'(want.err_tally));
                if (m_axis_tdata[74:59] != want.good_tally)
                    report_mismatch("good_frame_tally", 32'(m_axis_tdata[74:59]),
                                    32'(want.good_tally));
                if (m_axis_tdata[79:75] != '0)
                    report_mismatch("tdata padding", 32'(m_axis_tdata[79:75]), 32'd0);
                if (want.is_last) begin
                    case (want.status)
                        ST_OK:        n_ok++;
                        ST_CRC_ERR:   n_crc++;
                        ST_LEN_ERR:   n_len++;
                        default:      n_lost++;
                    endcase
                end else begin
                    n_data++;
                end
            end
        end
    end

    // output side: random stalls, or one long hold-off on request
    initial begin
        int len;
        m_axis_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_req) begin
                m_axis_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                rx_hold_req = 1'b0;
            end else if (idle_on && $urandom_range(0, 99) < 25) begin
                m_axis_tready = 1'b0;
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
                                                  : $urandom_range(1, 3);
                repeat (len - 1) @(negedge i_clk);
            end else begin
                m_axis_tready = 1'b1;
            end
        end
    end

    task automatic send_rx_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge i_clk);
        if (gap > 0) begin
            s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = b;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
        while (frame_results_due.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx idx, input logic [31:0] val);
        @(negedge i_clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (idx)
            REG_SYNC_PAT:     cfg_sync       = val[15:0];
            REG_COPY_LIMIT:   cfg_copy_limit = val[10:0];
            REG_RESYNC_LIMIT: cfg_resync     = val[6:0];
            default: ;
        endcase
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic fill_payload(input int len);
        payload_buf.delete();
        repeat (len) payload_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    // full frame from payload_buf; crc_flip != 0 corrupts the trailer
    task automatic send_frame(input logic [15:0] sync, input logic [7:0] cmd,
                              input logic [15:0] crc_flip);
        logic [15:0] crc;
        logic [15:0] len;
        len = 16'(payload_buf.size());
        crc = crc16_step(CRC_INIT, cmd);
        foreach (payload_buf[i]) crc = crc16_step(crc, payload_buf[i]);
        crc = crc ^ crc_flip;
        send_rx_byte(sync[15:8]);
        send_rx_byte(sync[7:0]);
        send_rx_byte(len[15:8]);
        send_rx_byte(len[7:0]);
        send_rx_byte(cmd);
        foreach (payload_buf[i]) send_rx_byte(payload_buf[i]);
        send_rx_byte(crc[15:8]);
        send_rx_byte(crc[7:0]);
    endtask

    task automatic send_len_error(input logic [15:0] len);
        send_rx_byte(cfg_sync[15:8]);
        send_rx_byte(cfg_sync[7:0]);
        send_rx_byte(len[15:8]);
        send_rx_byte(len[7:0]);
    endtask

    task automatic send_bad_sync();
        logic [15:0] w;
        w = 16'($urandom_range(0, 65535));
        if (w == cfg_sync) begin
            w[0] = ~w[0];
        end
        send_rx_byte(w[15:8]);
        send_rx_byte(w[7:0]);
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) begin
            return $urandom_range(65, 300);
        end else if (r < 20) begin
            return $urandom_range(17, 64);
        end
        return $urandom_range(0, 16);
    endfunction

    task automatic test_directed_cases();
        payload_buf.delete();
        send_frame(cfg_sync, 8'h00, 16'h0000);
        payload_buf = '{8'h00, 8'hFF};
        send_frame(cfg_sync, 8'hFF, 16'h8001);
        send_len_error(16'hFFFF);
        send_len_error(16'(PAYLOAD_LIMIT + 1));
        wait_drained();
        write_reg(REG_RESYNC_LIMIT, 32'd0);
        send_rx_byte(8'h12);
        send_rx_byte(8'h34);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int start;
        int r;
        int k;
        for (int ph = 0; ph < 4; ph++) begin
            wait_drained();
            case (ph)
                0: begin
                    write_reg(REG_SYNC_PAT, 32'h0000);
                    write_reg(REG_COPY_LIMIT, 32'd0);
                    write_reg(REG_RESYNC_LIMIT, 32'd127);
                end
                1: begin
                    write_reg(REG_SYNC_PAT, 32'hFFFF);
                    write_reg(REG_COPY_LIMIT, 32'd1024);
                    write_reg(REG_RESYNC_LIMIT, 32'd1);
                end
                2: begin
                    write_reg(REG_SYNC_PAT, $urandom_range(0, 65535));
                    write_reg(REG_COPY_LIMIT, $urandom_range(1, 16));
                    write_reg(REG_RESYNC_LIMIT, $urandom_range(2, 20));
                end
                default: begin
                    write_reg(REG_SYNC_PAT, 32'hAA55);
                    write_reg(REG_COPY_LIMIT, $urandom_range(0, 1024));
                    write_reg(REG_RESYNC_LIMIT, $urandom_range(0, 127));
                end
            endcase
            if (ph == 1) begin
                // largest legal payload, fully passed out
                idle_on = 1'b1;
                fill_payload(PAYLOAD_LIMIT);
                send_frame(cfg_sync, 8'($urandom_range(0, 255)), 16'h0000);
            end
            start = bytes_sent;
            while (bytes_sent - start < PHASE_BYTES) begin
                idle_on = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 70) begin
                    fill_payload(pick_len());
                    send_frame(cfg_sync, 8'($urandom_range(0, 255)), 16'h0000);
                end else if (r < 80) begin
                    fill_payload(pick_len());
                    send_frame(cfg_sync, 8'($urandom_range(0, 255)),
                               16'($urandom_range(1, 65535)));
                end else if (r < 85) begin
                    send_len_error(16'($urandom_range(PAYLOAD_LIMIT + 1, 65535)));
                end else if (r < 93) begin
                    send_bad_sync();
                    k = $urandom_range(0, 1) ? $urandom_range(0, 4)
                                             : int'(cfg_resync) + $urandom_range(0, 1);
                    repeat (k) send_rx_byte(8'($urandom_range(0, 255)));
                    fill_payload(pick_len());
                    send_frame(cfg_sync, 8'($urandom_range(0, 255)), 16'h0000);
                end else begin
                    repeat ($urandom_range(1, 6)) send_rx_byte(8'($urandom_range(0, 255)));
                end
            end
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        write_reg(REG_SYNC_PAT, 32'hAA55);
        write_reg(REG_COPY_LIMIT, 32'd1024);
        write_reg(REG_RESYNC_LIMIT, 32'd64);
        idle_on = 1'b0;
        @(negedge i_clk);
        rx_hold_req = 1'b1;
        repeat (4) begin
            fill_payload(8);
            send_frame(cfg_sync, 8'($urandom_range(0, 255)), 16'h0000);
        end
        wait_drained();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        parser_reset();
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;

        test_directed_cases();
        test_random_traffic();
        test_output_backpressure();

        repeat (10) @(posedge i_clk);
        $display("Fed %0d bytes: %0d good frames, %0d CRC errors, %0d length errors,",
                 bytes_sent, n_ok, n_crc, n_len);
        $display("%0d sync losses and %0d payload bytes, with stalls and one long hold-off",
                 n_lost, n_data);
        if (mismatches == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+sv
sv/slcfr_pkg.sv
sv/sync_length_crc_frame_receiver_core.sv
bench/sync_length_crc_frame_receiver_core_tb.sv
